>>> rtl/core/assert_macros.svh
// Assertion macros used by the RTL of the quadratic Bezier vertex generator.
// Checks compile away when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Invariant, disabled during reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)

`endif

`endif

>>> rtl/core/qbvg_pkg.sv
// Package for the quadratic Bezier vertex generator: item types, states,
// fixed widths and the round/saturate function. No dependencies.
package qbvg_pkg;

    localparam int COORD_W  = 16;
    localparam int IDX_W    = 6;
    localparam int VCNT_W   = 7;
    localparam int T_W      = 17;
    localparam int DIV_STEPS = T_W;
    localparam int DCNT_W   = 5;
    localparam int ACC_W    = 52;
    localparam int MA_W     = 34;
    localparam int MB_W     = 18;

    localparam logic [T_W-1:0]          T_ONE      = 17'h1_0000;
    localparam logic [VCNT_W-1:0]       VCNT_RESET = 7'd16;
    localparam logic [VCNT_W-1:0]       VCNT_MIN   = 7'd2;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = 52'sh0_0000_8000_0000;

    typedef logic [VCNT_W-1:0] t_cfg;
    typedef logic [IDX_W-1:0]  t_idx;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] control_x;
        logic signed [COORD_W-1:0] control_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
    } t_curve;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        t_idx                      point_index;
        logic                      last_point;
    } t_point;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_TT,
        S_AX,
        S_BX,
        S_AY,
        S_BY,
        S_FY,
        S_EMIT
    } t_state;

    function automatic logic signed [COORD_W-1:0] f_round_sat(
        input logic signed [ACC_W-1:0] s
    );
        logic signed [ACC_W-1:0]  b;
        logic signed [ACC_W-33:0] q;
        logic signed [COORD_W-1:0] r;
        b = s + ROUND_HALF;
        q = b[ACC_W-1:32];
        if (q > 20'sd32767) begin
            r = 16'sh7FFF;
        end else if (q < -20'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = q[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/core/qbvg_chan_if.sv
// Valid/ready channel interface for the quadratic Bezier vertex generator.
// Payload type is a parameter; used with types from qbvg_pkg.
interface qbvg_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/quadratic_bezier_vertex_generator.sv
// Quadratic Bezier vertex generator top level: sequencer, shared multiplier,
// reciprocal setup and output register. Depends on qbvg_pkg, qbvg_chan_if.
//
//   channel    dir   payload                                          role
//   i_curve    in    start_x/y, control_x/y, end_x/y (Q12.4)          one curve per item
//   o_point    out   point_x/y (Q12.4), point_index, last_point       one vertex per item
//   i_cfg      in    vertex_count (7 bits)                            register write
//
// A curve is accepted, then the bit-serial division 65536/(n-1) runs, then each vertex
// passes the TT, AX, BX, AY, BY, FY and EMIT steps through the one 34x18 multiplier.
// A stalled o_point holds the sequencer in its emit step; i_curve is not
// ready until the last vertex is loaded into the output register.
// Reset (synchronous, active low) clears control and sets vertex_count to 16.
`include "assert_macros.svh"

module quadratic_bezier_vertex_generator
    import qbvg_pkg::*;
#(
    parameter int MAX_VERTICES = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    qbvg_chan_if.sink                i_curve,
    qbvg_chan_if.source              o_point,
    qbvg_chan_if.sink                i_cfg
);

    localparam int CNT_W = $clog2(MAX_VERTICES);
    localparam logic [VCNT_W-1:0] MAX_N = VCNT_W'(MAX_VERTICES);

    t_state r_state, n_state;

    t_cfg               r_vertex_count;
    logic [CNT_W-1:0]   r_d;
    logic [CNT_W-1:0]   r_i;
    logic [CNT_W-1:0]   r_rem;
    logic [CNT_W-1:0]   r_r0;
    logic [DCNT_W-1:0]  r_cnt;
    logic [T_W-1:0]     r_q;
    logic [T_W-1:0]     r_t;
    logic [32:0]        r_tt;

    logic signed [COORD_W-1:0] r_p0x, r_p0y;
    logic signed [COORD_W:0]   r_ax, r_ay;
    logic signed [COORD_W+1:0] r_bx, r_by;

    logic signed [ACC_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [COORD_W-1:0] r_px;

    logic   r_ovalid;
    t_point r_out;

    logic                    in_ready;
    logic                    accept;
    logic                    emit_go;
    logic                    is_last;
    logic [VCNT_W-1:0]       n_eff;
    logic [CNT_W:0]          div_rs;
    logic                    div_ge;
    logic [CNT_W:0]          step_sum;
    logic                    step_ge;
    logic signed [MA_W-1:0]  mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic signed [ACC_W-1:0] prod;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_curve.valid) n_state = S_DIV;
            S_DIV:  if (r_cnt == DCNT_W'(DIV_STEPS - 1)) n_state = S_TT;
            S_TT:   n_state = S_AX;
            S_AX:   n_state = S_BX;
            S_BX:   n_state = S_AY;
            S_AY:   n_state = S_BY;
            S_BY:   n_state = S_FY;
            S_FY:   n_state = S_EMIT;
            S_EMIT: begin
                if (emit_go) begin
                    n_state = is_last ? S_IDLE : S_TT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        in_ready = 1'b0;
        emit_go  = 1'b0;
        case (r_state)
            S_IDLE:  in_ready = 1'b1;
            S_EMIT:  emit_go  = !r_ovalid || o_point.ready;
            default: begin
                in_ready = 1'b0;
                emit_go  = 1'b0;
            end
        endcase
    end

    assign accept  = i_curve.valid && in_ready;
    assign is_last = (r_i == r_d);

    assign i_curve.ready = in_ready;
    assign i_cfg.ready   = 1'b1;
    assign o_point.valid = r_ovalid;
    assign o_point.data  = r_out;

    always_comb begin
        n_eff = r_vertex_count;
        if (r_vertex_count < VCNT_MIN) n_eff = VCNT_MIN;
        if (r_vertex_count > MAX_N)    n_eff = MAX_N;
    end

    // restoring division step and per-vertex t step
    assign div_rs   = {r_rem, r_q[T_W-1]};
    assign div_ge   = div_rs >= {1'b0, r_d};
    assign step_sum = {1'b0, r_rem} + {1'b0, r_r0};
    assign step_ge  = step_sum >= {1'b0, r_d};

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_TT: begin
                mul_a = $signed({{(MA_W-T_W){1'b0}}, r_t});
                mul_b = $signed({1'b0, r_t});
            end
            S_AX: begin
                mul_a = $signed({{(MA_W-T_W){1'b0}}, r_t});
                mul_b = {r_ax[COORD_W], r_ax};
            end
            S_BX: begin
                mul_a = $signed({1'b0, r_tt});
                mul_b = r_bx;
            end
            S_AY: begin
                mul_a = $signed({{(MA_W-T_W){1'b0}}, r_t});
                mul_b = {r_ay[COORD_W], r_ay};
            end
            S_BY: begin
                mul_a = $signed({1'b0, r_tt});
                mul_b = r_by;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = ACC_W'(mul_a * mul_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_vertex_count <= VCNT_RESET;
            r_ovalid       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                r_vertex_count <= i_cfg.data;
            end
            if (emit_go) begin
                r_ovalid <= 1'b1;
            end else if (o_point.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_p0x <= i_curve.data.start_x;
                    r_p0y <= i_curve.data.start_y;
                    r_ax  <= {i_curve.data.control_x[COORD_W-1], i_curve.data.control_x}
                           - {i_curve.data.start_x[COORD_W-1], i_curve.data.start_x};
                    r_ay  <= {i_curve.data.control_y[COORD_W-1], i_curve.data.control_y}
                           - {i_curve.data.start_y[COORD_W-1], i_curve.data.start_y};
                    r_bx  <= {{2{i_curve.data.start_x[COORD_W-1]}}, i_curve.data.start_x}
                           - {i_curve.data.control_x[COORD_W-1], i_curve.data.control_x, 1'b0}
                           + {{2{i_curve.data.end_x[COORD_W-1]}}, i_curve.data.end_x};
                    r_by  <= {{2{i_curve.data.start_y[COORD_W-1]}}, i_curve.data.start_y}
                           - {i_curve.data.control_y[COORD_W-1], i_curve.data.control_y, 1'b0}
                           + {{2{i_curve.data.end_y[COORD_W-1]}}, i_curve.data.end_y};
                    r_d   <= CNT_W'(n_eff - 7'd1);
                    r_q   <= T_ONE;
                    r_rem <= '0;
                    r_cnt <= '0;
                end
            end
            S_DIV: begin
                r_q   <= {r_q[T_W-2:0], div_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DCNT_W'(DIV_STEPS - 1)) begin
                    r_r0  <= div_ge ? CNT_W'(div_rs - {1'b0, r_d}) : div_rs[CNT_W-1:0];
                    r_rem <= '0;
                    r_t   <= '0;
                    r_i   <= '0;
                end else begin
                    r_rem <= div_ge ? CNT_W'(div_rs - {1'b0, r_d}) : div_rs[CNT_W-1:0];
                end
            end
            S_TT: begin
                r_prod <= prod;
            end
            S_AX: begin
                r_tt   <= r_prod[32:0];
                r_prod <= prod;
            end
            S_BX: begin
                r_acc  <= {{(ACC_W-COORD_W-32){r_p0x[COORD_W-1]}}, r_p0x, 32'b0}
                        + {r_prod[ACC_W-18:0], 17'b0};
                r_prod <= prod;
            end
            S_AY: begin
                r_acc  <= r_acc + r_prod;
                r_prod <= prod;
            end
            S_BY: begin
                r_px   <= f_round_sat(r_acc);
                r_acc  <= {{(ACC_W-COORD_W-32){r_p0y[COORD_W-1]}}, r_p0y, 32'b0}
                        + {r_prod[ACC_W-18:0], 17'b0};
                r_prod <= prod;
            end
            S_FY: begin
                r_acc <= r_acc + r_prod;
            end
            S_EMIT: begin
                if (emit_go) begin
                    r_out.point_x     <= r_px;
                    r_out.point_y     <= f_round_sat(r_acc);
                    r_out.point_index <= t_idx'(r_i);
                    r_out.last_point  <= is_last;
                    r_i <= r_i + 1'b1;
                    if (step_ge) begin
                        r_rem <= CNT_W'(step_sum - {1'b0, r_d});
                        r_t   <= r_t + r_q + 1'b1;
                    end else begin
                        r_rem <= step_sum[CNT_W-1:0];
                        r_t   <= r_t + r_q;
                    end
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    `ASSERT_NEXT(a_accept_div, i_clk, i_rst_n, accept, r_state == S_DIV)
    `ASSERT_IMPLY(a_first_t_zero, i_clk, i_rst_n, r_state == S_TT && r_i == '0, r_t == '0)
    `ASSERT_IMPLY(a_last_t_one, i_clk, i_rst_n, r_state == S_TT && is_last, r_t == T_ONE)
    `ASSERT_IMPLY(a_last_flag, i_clk, i_rst_n, emit_go, n_state == (is_last ? S_IDLE : S_TT))
    `ASSERT_IMPLY(a_idx_range, i_clk, i_rst_n, r_state == S_EMIT, r_i <= r_d)

endmodule
